// ----- hw/rtl/qcsw_pkg.sv -----
// package for the quadrature counter with windowed speed
// configuration register codes, reset values and the config bundle type
// no dependencies
package qcsw_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_MS      = 2'd0;
    localparam logic [1:0] CFG_SPEED_SCALE    = 2'd1;
    localparam logic [1:0] CFG_POSITION_SCALE = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [15:0] SAMPLE_MS_RST      = 16'd100;
    localparam logic [31:0] SPEED_SCALE_RST    = 32'd65536;
    localparam logic [31:0] POSITION_SCALE_RST = 32'd65536;

    // elapsed millisecond counter ceiling
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // output widths fixed by the interface
    localparam int SPEED_W  = 48;
    localparam int SCALED_W = 64;
    localparam int COUNT_W  = 32;

    typedef struct packed {
        logic [15:0] sample_ms;
        logic [31:0] speed_scale;
        logic [31:0] position_scale;
    } t_cfg;

endpackage

// ----- hw/rtl/qcsw_decode.sv -----
// edge decoder, position and window counters, window timer
// first pipeline stage; depends on qcsw_pkg
module qcsw_decode import qcsw_pkg::*; #(
    parameter int POS_WIDTH = 32,
    parameter int WIN_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_enc_a,
    input  logic                        i_enc_b,
    input  logic                        i_ms_tick,
    input  t_cfg                        i_cfg,
    input  logic                        i_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [POS_WIDTH-1:0]        o_total,
    output logic signed [WIN_WIDTH-1:0] o_win,
    output logic                        o_update
);

    localparam logic signed [WIN_WIDTH-1:0] WIN_MAX = {1'b0, {(WIN_WIDTH-1){1'b1}}};
    localparam logic signed [WIN_WIDTH-1:0] WIN_MIN = {1'b1, {(WIN_WIDTH-1){1'b0}}};

    logic                        r_last_a;
    logic                        r_last_b;
    logic [POS_WIDTH-1:0]        r_total;
    logic signed [WIN_WIDTH-1:0] r_win;
    logic [15:0]                 r_elapsed;
    logic                        r_valid;

    logic                        acc;
    logic                        rise_a;
    logic                        rise_b;
    logic                        up_a;
    logic                        up_b;
    logic [POS_WIDTH-1:0]        t_a;
    logic [POS_WIDTH-1:0]        n_total;
    logic signed [WIN_WIDTH-1:0] w_a;
    logic signed [WIN_WIDTH-1:0] n_win_cnt;
    logic [15:0]                 n_elapsed;
    logic                        close;

    // one saturating step of the window count
    function automatic logic signed [WIN_WIDTH-1:0] win_step(
        input logic signed [WIN_WIDTH-1:0] w,
        input logic                        rise,
        input logic                        up
    );
        logic signed [WIN_WIDTH-1:0] r;
        r = w;
        if (rise && up && (w != WIN_MAX)) begin
            r = w + WIN_WIDTH'(1);
        end else if (rise && !up && (w != WIN_MIN)) begin
            r = w - WIN_WIDTH'(1);
        end
        return r;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;

    // x2 decoding on rising edges
    assign rise_a = i_enc_a && !r_last_a;
    assign rise_b = i_enc_b && !r_last_b;
    assign up_a   = !i_enc_b;
    assign up_b   = i_enc_a;

    // wrapping position count, channel a then channel b
    always_comb begin
        t_a = r_total;
        if (rise_a) begin
            t_a = up_a ? r_total + POS_WIDTH'(1) : r_total - POS_WIDTH'(1);
        end
        n_total = t_a;
        if (rise_b) begin
            n_total = up_b ? t_a + POS_WIDTH'(1) : t_a - POS_WIDTH'(1);
        end
    end

    // saturating window count, each edge saturates on its own
    assign w_a       = win_step(r_win, rise_a, up_a);
    assign n_win_cnt = win_step(w_a, rise_b, up_b);

    // millisecond timer and window close
    assign n_elapsed = (i_ms_tick && (r_elapsed != ELAPSED_MAX)) ?
                       r_elapsed + 16'd1 : r_elapsed;
    assign close     = (n_elapsed >= i_cfg.sample_ms);

    // counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a  <= 1'b0;
            r_last_b  <= 1'b0;
            r_total   <= '0;
            r_win     <= '0;
            r_elapsed <= '0;
        end else if (acc) begin
            r_last_a  <= i_enc_a;
            r_last_b  <= i_enc_b;
            r_total   <= n_total;
            r_win     <= close ? '0 : n_win_cnt;
            r_elapsed <= close ? 16'd0 : n_elapsed;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_total  <= n_total;
            o_win    <= n_win_cnt;
            o_update <= close;
        end
    end

    assign o_valid = r_valid;

    // window closes clear the window state
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && close |=> (r_win == '0) && (r_elapsed == 16'd0))
        else $error("window state not cleared on close");

    // counters move only on a transfer
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_total) && $stable(r_win) && $stable(r_elapsed))
        else $error("counter state changed without a transfer");

endmodule

// ----- hw/rtl/qcsw_scale.sv -----
// scaling pipeline: partial products, sums, saturation, held speed, result register
// stages two to four; depends on qcsw_pkg
module qcsw_scale import qcsw_pkg::*; #(
    parameter int POS_WIDTH = 32,
    parameter int WIN_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [POS_WIDTH-1:0]        i_total,
    input  logic signed [WIN_WIDTH-1:0] i_win,
    input  logic                        i_update,
    input  t_cfg                        i_cfg,
    input  logic                        i_stall,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic signed [COUNT_W-1:0]   o_position_count,
    output logic signed [SCALED_W-1:0]  o_position_scaled,
    output logic signed [SPEED_W-1:0]   o_speed_value,
    output logic                        o_speed_update
);

    // split of the position for the partial products
    localparam int H    = (POS_WIDTH + 1) / 2;
    localparam int LO_W = H + 32;
    localparam int HI_W = POS_WIDTH - H + 33;
    localparam int PW   = POS_WIDTH + 33;
    localparam int EW   = (PW > SCALED_W) ? PW : SCALED_W + 1;
    localparam int SP_W = WIN_WIDTH + 33;
    localparam int SE   = (SP_W > SPEED_W) ? SP_W : SPEED_W + 1;

    localparam logic signed [SCALED_W-1:0] POS_HI = {1'b0, {(SCALED_W-1){1'b1}}};
    localparam logic signed [SCALED_W-1:0] POS_LO = {1'b1, {(SCALED_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0]  SPD_HI = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0]  SPD_LO = {1'b1, {(SPEED_W-1){1'b0}}};

    // stage two
    logic                       r2_valid;
    logic [LO_W-1:0]            r2_lo;
    logic signed [HI_W-1:0]     r2_hi;
    logic signed [SP_W-1:0]     r2_spd;
    logic                       r2_upd;
    logic [COUNT_W-1:0]         r2_cnt;
    // stage three
    logic                       r3_valid;
    logic signed [PW-1:0]       r3_prod;
    logic                       r3_upd;
    logic [COUNT_W-1:0]         r3_cnt;
    logic signed [SPEED_W-1:0]  r_held;
    // stage four
    logic                       r4_valid;

    logic                       rdy2;
    logic                       rdy3;
    logic                       rdy4;
    logic                       adv3;
    logic signed [63:0]         tot_ext;
    logic [LO_W-1:0]            w_lo;
    logic signed [HI_W-1:0]     w_hi;
    logic signed [SP_W-1:0]     w_spd;
    logic signed [PW-1:0]       w_prod;
    logic signed [SE-1:0]       spd_ext;
    logic signed [SPEED_W-1:0]  spd_sat;
    logic signed [SPEED_W-1:0]  n_held;
    logic signed [EW-1:0]       pos_ext;
    logic signed [SCALED_W-1:0] pos_sat;

    // ready chain
    assign rdy4    = !r4_valid || !i_stall;
    assign rdy3    = !r3_valid || rdy4;
    assign rdy2    = !r2_valid || rdy3;
    assign o_ready = rdy2;
    assign adv3    = rdy3 && r2_valid;

    // partial products and speed product
    assign tot_ext = 64'($signed(i_total));
    assign w_lo    = LO_W'(i_total[H-1:0]) * LO_W'(i_cfg.position_scale);
    assign w_hi    = HI_W'($signed(i_total[POS_WIDTH-1:H]))
                   * HI_W'($signed({1'b0, i_cfg.position_scale}));
    assign w_spd   = SP_W'(i_win) * SP_W'($signed({1'b0, i_cfg.speed_scale}));

    // speed saturation and held value
    assign spd_ext = SE'(r2_spd);
    always_comb begin
        if ((&spd_ext[SE-1:SPEED_W-1]) || !(|spd_ext[SE-1:SPEED_W-1])) begin
            spd_sat = spd_ext[SPEED_W-1:0];
        end else begin
            spd_sat = spd_ext[SE-1] ? SPD_LO : SPD_HI;
        end
    end
    assign n_held = r2_upd ? spd_sat : r_held;

    // full position product
    assign w_prod = (PW'(r2_hi) <<< H) + $signed(PW'(r2_lo));

    // position saturation
    assign pos_ext = EW'(r3_prod);
    always_comb begin
        if ((&pos_ext[EW-1:SCALED_W-1]) || !(|pos_ext[EW-1:SCALED_W-1])) begin
            pos_sat = pos_ext[SCALED_W-1:0];
        end else begin
            pos_sat = pos_ext[EW-1] ? POS_LO : POS_HI;
        end
    end

    // stage valids and held speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_held   <= '0;
        end else begin
            if (rdy2) begin
                r2_valid <= i_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
            if (adv3) begin
                r_held <= n_held;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r2_lo  <= w_lo;
            r2_hi  <= w_hi;
            r2_spd <= w_spd;
            r2_upd <= i_update;
            r2_cnt <= tot_ext[COUNT_W-1:0];
        end
        if (adv3) begin
            r3_prod <= w_prod;
            r3_upd  <= r2_upd;
            r3_cnt  <= r2_cnt;
        end
        if (rdy4 && r3_valid) begin
            o_position_scaled <= pos_sat;
            o_speed_value     <= r_held;
            o_speed_update    <= r3_upd;
            o_position_count  <= $signed(r3_cnt);
        end
    end

    assign o_valid = r4_valid;

    // held speed moves only when a closing item enters stage three
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv3 && r2_upd) |=> $stable(r_held))
        else $error("held speed changed without a window close");

    // a blocked stage keeps its item
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid && !rdy4 |=> r3_valid && $stable(r3_prod))
        else $error("stage three item lost under stall");

endmodule

// ----- hw/rtl/quadrature_counter_speed_window.sv -----
// a result passes in order through the decode stage and the registers of stages two, three and four
// throughput: one item per cycle while i_stall is low; the four-stage pipeline with a ready chain sets this
// the position product is split into two partial products over stages two and three
// reset (synchronous, active low) clears counters, held speed and pipeline valids,
// and returns the configuration registers to their defaults
// top level: configuration registers, decode stage, scaling pipeline; depends on qcsw_pkg
module quadrature_counter_speed_window import qcsw_pkg::*; #(
    parameter int POS_WIDTH = 32,
    parameter int WIN_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_enc_a,
    input  logic                       i_enc_b,
    input  logic                       i_ms_tick,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [COUNT_W-1:0]  o_position_count,
    output logic signed [SCALED_W-1:0] o_position_scaled,
    output logic signed [SPEED_W-1:0]  o_speed_value,
    output logic                       o_speed_update
);

    t_cfg                        r_cfg;
    logic                        dec_ready;
    logic                        scl_ready;
    logic                        s1_valid;
    logic [POS_WIDTH-1:0]        s1_total;
    logic signed [WIN_WIDTH-1:0] s1_win;
    logic                        s1_update;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_ms      <= SAMPLE_MS_RST;
            r_cfg.speed_scale    <= SPEED_SCALE_RST;
            r_cfg.position_scale <= POSITION_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_MS:      r_cfg.sample_ms      <= i_cfg_data[15:0];
                CFG_SPEED_SCALE:    r_cfg.speed_scale    <= i_cfg_data;
                CFG_POSITION_SCALE: r_cfg.position_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stall = !dec_ready;

    // edge decode and counters
    qcsw_decode #(
        .POS_WIDTH (POS_WIDTH),
        .WIN_WIDTH (WIN_WIDTH)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_enc_a   (i_enc_a),
        .i_enc_b   (i_enc_b),
        .i_ms_tick (i_ms_tick),
        .i_cfg     (r_cfg),
        .i_ready   (scl_ready),
        .o_ready   (dec_ready),
        .o_valid   (s1_valid),
        .o_total   (s1_total),
        .o_win     (s1_win),
        .o_update  (s1_update)
    );

    // scaling and result register
    qcsw_scale #(
        .POS_WIDTH (POS_WIDTH),
        .WIN_WIDTH (WIN_WIDTH)
    ) u_scale (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s1_valid),
        .i_total           (s1_total),
        .i_win             (s1_win),
        .i_update          (s1_update),
        .i_cfg             (r_cfg),
        .i_stall           (i_stall),
        .o_ready           (scl_ready),
        .o_valid           (o_valid),
        .o_position_count  (o_position_count),
        .o_position_scaled (o_position_scaled),
        .o_speed_value     (o_speed_value),
        .o_speed_update    (o_speed_update)
    );

endmodule
